/* design/u8d_pkg.sv */
// Shared types and constants for the UTF-8 stream decoder.
package u8d_pkg;

    localparam int CP_W = 21;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD  = 3'd1;
    localparam logic [2:0] ST_TRUNCATED = 3'd2;
    localparam logic [2:0] ST_ABOVE     = 3'd3;
    localparam logic [2:0] ST_OVERLONG  = 3'd4;
    localparam logic [2:0] ST_SURROGATE = 3'd5;

    localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;

    // One queue entry: the results caused by one input byte.
    // Result 0 uses cp0/n0/st0; results 1..cnt-1 use cp1, one byte, st1.
    typedef struct packed {
        logic [CP_W-1:0] cp0;
        logic [2:0]      n0;
        logic [2:0]      st0;
        logic [CP_W-1:0] cp1;
        logic [2:0]      st1;
        logic [2:0]      cnt;
    } cmd_t;

endpackage

/* design/utf8_stream_decoder.sv */
// Top level: streaming UTF-8 decoder, one byte in, code points with status out.
// A byte that completes a unit is written into the command queue when it is accepted, and its
// first result is then loaded into the output register, from which it can be popped.
// Throughput: one byte per cycle until full rises; the back end delivers one result per cycle
// while pop is high, so a byte with two or four results holds the back end longer and the
// command queue (QUEUE_DEPTH entries) absorbs the difference until full rises.
// Reset: rst_n clears the open sequence, the queue and the output register at once.
module utf8_stream_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    output logic                     full,
    input  logic [7:0]               byte_in,
    output logic                     empty,
    input  logic                     pop,
    output logic [u8d_pkg::CP_W-1:0] codepoint,
    output logic [2:0]               seq_bytes,
    output logic [2:0]               status,
    output logic                     last
);
    import u8d_pkg::*;

    logic accept;
    logic cmd_push;
    cmd_t cmd;
    cmd_t head;
    logic head_pop;
    logic head_empty;

    assign accept = push && !full;

    u8d_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .byte_in  (byte_in),
        .cmd_push (cmd_push),
        .cmd      (cmd)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd),
        .pop       (head_pop),
        .head      (head),
        .full      (full),
        .empty     (head_empty)
    );

    u8d_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_empty (head_empty),
        .head_pop   (head_pop),
        .pop        (pop),
        .empty      (empty),
        .codepoint  (codepoint),
        .seq_bytes  (seq_bytes),
        .status     (status),
        .last       (last)
    );

    // Bad leads and above-range results always stand for a single replaced byte.
    a_bad_lead_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && (status == ST_BAD_LEAD || status == ST_ABOVE))
            |-> (codepoint == CP_REPLACEMENT && seq_bytes == 3'd1))
        else $error("bad lead or above-range result malformed");

    // The above-range result leads a burst of four and is never the final one.
    a_above_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_ABOVE) |-> !last)
        else $error("above-range result marked last");

    // A truncated sequence covers one to three bytes.
    a_trunc_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_TRUNCATED)
            |-> (seq_bytes == 3'd1 || seq_bytes == 3'd2 || seq_bytes == 3'd3))
        else $error("truncated result with bad length");

    // A command is only sent into the queue for an accepted byte.
    a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_push |-> accept)
        else $error("queue written without an accepted byte");

endmodule

/* design/u8d_front.sv */
// Front end: accepts bytes, tracks the open sequence and builds result commands.
module u8d_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    byte_in,
    output logic          cmd_push,
    output u8d_pkg::cmd_t cmd
);
    import u8d_pkg::*;

    logic [CP_W-1:0] partial_reg, partial_next;
    logic [2:0]      expected_reg, expected_next;
    logic [2:0]      seen_reg, seen_next;

    logic [2:0]      lead_len;
    logic [CP_W-1:0] lead_bits;
    logic [CP_W-1:0] lead_cp;
    logic [2:0]      lead_st;
    logic            lead_opens;
    logic            is_cont;
    logic [CP_W-1:0] cont_value;
    logic [2:0]      cont_seen;
    logic [2:0]      min_len;

    // Classify the incoming byte as a lead.
    always_comb
    begin
        lead_len  = 3'd0;
        lead_bits = '0;
        if (byte_in[7:5] == 3'b110)
        begin
            lead_len  = 3'd2;
            lead_bits = CP_W'(byte_in & 8'h1F);
        end
        else if (byte_in[7:4] == 4'b1110)
        begin
            lead_len  = 3'd3;
            lead_bits = CP_W'(byte_in & 8'h0F);
        end
        else if (byte_in[7:3] == 5'b11110)
        begin
            lead_len  = 3'd4;
            lead_bits = CP_W'(byte_in & 8'h07);
        end
        lead_opens = (lead_len != 3'd0);
        lead_cp    = byte_in[7] ? CP_REPLACEMENT : CP_W'(byte_in);
        lead_st    = byte_in[7] ? ST_BAD_LEAD : ST_OK;
    end

    assign is_cont    = (byte_in[7:6] == 2'b10);
    assign cont_value = {partial_reg[CP_W-7:0], byte_in[5:0]};
    assign cont_seen  = 3'(seen_reg + 3'd1);

    always_comb
    begin
        if (cont_value < 21'h80)
            min_len = 3'd1;
        else if (cont_value < 21'h800)
            min_len = 3'd2;
        else if (cont_value < 21'h10000)
            min_len = 3'd3;
        else
            min_len = 3'd4;
    end

    always_comb
    begin
        partial_next  = partial_reg;
        expected_next = expected_reg;
        seen_next     = seen_reg;
        cmd_push      = 1'b0;
        cmd           = '0;
        if (accept)
        begin
            if (expected_reg == 3'd0)
            begin
                if (lead_opens)
                begin
                    partial_next  = lead_bits;
                    expected_next = lead_len;
                    seen_next     = 3'd1;
                end
                else
                begin
                    cmd_push = 1'b1;
                    cmd.cp0  = lead_cp;
                    cmd.n0   = 3'd1;
                    cmd.st0  = lead_st;
                    cmd.cnt  = 3'd1;
                end
            end
            else if (is_cont)
            begin
                if (cont_seen >= expected_reg)
                begin
                    partial_next  = '0;
                    expected_next = 3'd0;
                    seen_next     = 3'd0;
                    cmd_push      = 1'b1;
                    if (expected_reg == 3'd4 && cont_value > CP_MAX)
                    begin
                        // lead flagged above range, its continuations as bad leads
                        cmd.cp0 = CP_REPLACEMENT;
                        cmd.n0  = 3'd1;
                        cmd.st0 = ST_ABOVE;
                        cmd.cp1 = CP_REPLACEMENT;
                        cmd.st1 = ST_BAD_LEAD;
                        cmd.cnt = 3'd4;
                    end
                    else
                    begin
                        cmd.cp0 = cont_value;
                        cmd.n0  = expected_reg;
                        if (min_len < expected_reg)
                            cmd.st0 = ST_OVERLONG;
                        else if (cont_value >= 21'h00D800 && cont_value <= 21'h00DFFF)
                            cmd.st0 = ST_SURROGATE;
                        else
                            cmd.st0 = ST_OK;
                        cmd.cnt = 3'd1;
                    end
                end
                else
                begin
                    partial_next = cont_value;
                    seen_next    = cont_seen;
                end
            end
            else
            begin
                // Broken sequence: report it, then decode the byte as a fresh lead.
                cmd_push = 1'b1;
                cmd.cp0  = CP_REPLACEMENT;
                cmd.n0   = seen_reg;
                cmd.st0  = ST_TRUNCATED;
                if (lead_opens)
                begin
                    partial_next  = lead_bits;
                    expected_next = lead_len;
                    seen_next     = 3'd1;
                    cmd.cnt       = 3'd1;
                end
                else
                begin
                    partial_next  = '0;
                    expected_next = 3'd0;
                    seen_next     = 3'd0;
                    cmd.cp1       = lead_cp;
                    cmd.st1       = lead_st;
                    cmd.cnt       = 3'd2;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg  <= '0;
            expected_reg <= 3'd0;
            seen_reg     <= 3'd0;
        end
        else
        begin
            partial_reg  <= partial_next;
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
        end
    end

endmodule

/* design/u8d_queue.sv */
// Short command queue between the front and back ends.
module u8d_queue #(
    parameter int DEPTH = 4
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  u8d_pkg::cmd_t push_data,
    input  logic          pop,
    output u8d_pkg::cmd_t head,
    output logic          full,
    output logic          empty
);
    import u8d_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : PTR_W'(wr_ptr_reg + 1'b1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : PTR_W'(rd_ptr_reg + 1'b1);
        if (do_push && !do_pop)
            count_next = CNT_W'(count_reg + 1'b1);
        else if (do_pop && !do_push)
            count_next = CNT_W'(count_reg - 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

/* design/u8d_back.sv */
// Back end: expands each command into its results and holds them in an output register.
module u8d_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  u8d_pkg::cmd_t            head,
    input  logic                     head_empty,
    output logic                     head_pop,
    input  logic                     pop,
    output logic                     empty,
    output logic [u8d_pkg::CP_W-1:0] codepoint,
    output logic [2:0]               seq_bytes,
    output logic [2:0]               status,
    output logic                     last
);
    import u8d_pkg::*;

    logic            valid_reg, valid_next;
    logic [1:0]      idx_reg, idx_next;
    logic [CP_W-1:0] cp_reg, cp_next;
    logic [2:0]      n_reg, n_next;
    logic [2:0]      st_reg, st_next;
    logic            last_reg, last_next;
    logic            load;
    logic            final_result;

    assign load         = (!valid_reg || pop) && !head_empty;
    assign final_result = ({1'b0, idx_reg} == 3'(head.cnt - 3'd1));
    assign head_pop     = load && final_result;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        cp_next    = cp_reg;
        n_next     = n_reg;
        st_next    = st_reg;
        last_next  = last_reg;
        if (load)
        begin
            valid_next = 1'b1;
            last_next  = final_result;
            idx_next   = final_result ? 2'd0 : 2'(idx_reg + 2'd1);
            if (idx_reg == 2'd0)
            begin
                cp_next = head.cp0;
                n_next  = head.n0;
                st_next = head.st0;
            end
            else
            begin
                cp_next = head.cp1;
                n_next  = 3'd1;
                st_next = head.st1;
            end
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cp_reg   <= cp_next;
        n_reg    <= n_next;
        st_reg   <= st_next;
        last_reg <= last_next;
    end

    assign empty     = !valid_reg;
    assign codepoint = cp_reg;
    assign seq_bytes = n_reg;
    assign status    = st_reg;
    assign last      = last_reg;

endmodule

/* tb/utf8_stream_decoder_tb.sv */
// Self-checking testbench for the UTF-8 stream decoder: directed and random byte streams.
`timescale 1ns / 1ps

module utf8_stream_decoder_tb;
    import u8d_pkg::*;

    localparam int QUIET_LIMIT  = 4000;
    localparam int TAIL_CYCLES  = 20;
    localparam int PHASE_BYTES  = 112;

    // Tracks the decoder's sequence state and holds the code points it must produce.
    class codepoint_tracker;
        typedef struct packed {
            logic [CP_W-1:0] cp;
            logic [2:0]      n;
            logic [2:0]      st;
            logic            fin;
        } unit_t;

        unit_t           codepoint_q[$];
        logic [CP_W-1:0] acc;
        logic [2:0]      want_len;
        logic [2:0]      seen_len;
        int              mismatches;

        function new();
            acc        = '0;
            want_len   = '0;
            seen_len   = '0;
            mismatches = 0;
        endfunction

        function void report(string msg);
            $display("[%0t] MISMATCH: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void add_unit(logic [CP_W-1:0] cp, logic [2:0] n, logic [2:0] st);
            unit_t u;
            u.cp  = cp;
            u.n   = n;
            u.st  = st;
            u.fin = 1'b0;
            codepoint_q.push_back(u);
        endfunction

        function void clear_seq();
            acc      = '0;
            want_len = '0;
            seen_len = '0;
        endfunction

        function int min_len(logic [CP_W-1:0] cp);
            if (cp < 21'h80)
                return 1;
            if (cp < 21'h800)
                return 2;
            if (cp < 21'h10000)
                return 3;
            return 4;
        endfunction

        function void take_lead(logic [7:0] b);
            if (b < 8'h80)
                add_unit({13'd0, b}, 3'd1, ST_OK);
            else if (b >= 8'hC0 && b <= 8'hDF)
            begin
                acc      = {16'd0, b[4:0]};
                want_len = 3'd2;
                seen_len = 3'd1;
            end
            else if (b >= 8'hE0 && b <= 8'hEF)
            begin
                acc      = {17'd0, b[3:0]};
                want_len = 3'd3;
                seen_len = 3'd1;
            end
            else if (b >= 8'hF0 && b <= 8'hF7)
            begin
                acc      = {18'd0, b[2:0]};
                want_len = 3'd4;
                seen_len = 3'd1;
            end
            else
                add_unit(CP_REPLACEMENT, 3'd1, ST_BAD_LEAD);
        endfunction

        function void note_byte(logic [7:0] b);
            int              base;
            logic [CP_W-1:0] cp;
            logic [2:0]      n;
            logic [2:0]      st;
            unit_t           u;
            base = codepoint_q.size();
            if (want_len == 3'd0)
                take_lead(b);
            else if (b[7:6] == 2'b10)
            begin
                acc      = {acc[CP_W-7:0], b[5:0]};
                seen_len = seen_len + 3'd1;
                if (seen_len >= want_len)
                begin
                    cp = acc;
                    n  = want_len;
                    clear_seq();
                    if (n == 3'd4 && cp > CP_MAX)
                    begin
                        // lead flagged above range, its continuations come back as bad leads
                        add_unit(CP_REPLACEMENT, 3'd1, ST_ABOVE);
                        repeat (3) add_unit(CP_REPLACEMENT, 3'd1, ST_BAD_LEAD);
                    end
                    else
                    begin
                        st = ST_OK;
                        if (min_len(cp) < int'(n))
                            st = ST_OVERLONG;
                        else if (cp >= 21'hD800 && cp <= 21'hDFFF)
                            st = ST_SURROGATE;
                        add_unit(cp, n, st);
                    end
                end
            end
            else
            begin
                // close the broken sequence, then decode the breaking byte afresh
                n = seen_len;
                clear_seq();
                add_unit(CP_REPLACEMENT, n, ST_TRUNCATED);
                take_lead(b);
            end
            if (codepoint_q.size() > base)
            begin
                u     = codepoint_q.pop_back();
                u.fin = 1'b1;
                codepoint_q.push_back(u);
            end
        endfunction

        function void check_result(logic [CP_W-1:0] cp, logic [2:0] n, logic [2:0] st,
                                   logic fin);
            unit_t u;
            if (codepoint_q.size() == 0)
            begin
                report($sformatf("unexpected result cp=%h n=%0d st=%0d last=%0b",
                                 cp, n, st, fin));
                return;
            end
            u = codepoint_q.pop_front();
            if (cp !== u.cp)
                report($sformatf("codepoint got %h want %h", cp, u.cp));
            if (n !== u.n)
                report($sformatf("seq_bytes got %0d want %0d (cp %h)", n, u.n, u.cp));
            if (st !== u.st)
                report($sformatf("status got %0d want %0d (cp %h)", st, u.st, u.cp));
            if (fin !== u.fin)
                report($sformatf("last got %0b want %0b (cp %h)", fin, u.fin, u.cp));
        endfunction
    endclass

    logic            clk;
    logic            rst_n;
    logic            push;
    logic            full;
    logic [7:0]      byte_in;
    logic            empty;
    logic            pop;
    logic [CP_W-1:0] codepoint;
    logic [2:0]      seq_bytes;
    logic [2:0]      status;
    logic            last;

    codepoint_tracker sb = new();
    int               sender_idle_pct;
    int               stall_pct;
    int               bytes_sent;
    int               quiet_cycles;
    logic [7:0]       directed_seq[$];

    utf8_stream_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_in   (byte_in),
        .empty     (empty),
        .pop       (pop),
        .codepoint (codepoint),
        .seq_bytes (seq_bytes),
        .status    (status),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // Score accepted requests and results; end the run if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (push && !full)
                sb.note_byte(byte_in);
            if (pop && !empty)
                sb.check_result(codepoint, seq_bytes, status, last);
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push    <= 1'b1;
        byte_in <= b;
        do
            @(posedge clk);
        while (full);
        bytes_sent++;
    endtask

    // Encode cp in len bytes; send the lead and only the first ncont continuations.
    task automatic send_cp(input logic [CP_W-1:0] cp, input int len, input int ncont);
        logic [7:0]      lead_b;
        logic [CP_W-1:0] tmp;
        int              k;
        case (len)
            1:       lead_b = {1'b0, cp[6:0]};
            2:       lead_b = {3'b110, cp[10:6]};
            3:       lead_b = {4'b1110, cp[15:12]};
            default: lead_b = {5'b11110, cp[20:18]};
        endcase
        send_byte(lead_b);
        for (k = 0; k < ncont; k++)
        begin
            tmp = cp >> (6 * (len - 2 - k));
            send_byte({2'b10, tmp[5:0]});
        end
    endtask

    task automatic send_random_unit();
        int         pick;
        int         len;
        int         k;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            send_cp(CP_W'($urandom_range(0, 8'h7F)), 1, 0);
        else if (pick < 30)
            send_cp(CP_W'($urandom_range(21'h80, 21'h7FF)), 2, 1);
        else if (pick < 45)
            send_cp(CP_W'($urandom_range(21'h800, 21'hFFFF)), 3, 2);
        else if (pick < 58)
            send_cp(CP_W'($urandom_range(21'h10000, 21'h10FFFF)), 4, 3);
        else if (pick < 64)
            send_cp(CP_W'($urandom_range(21'hD800, 21'hDFFF)), 3, 2);
        else if (pick < 72)
        begin
            len = $urandom_range(2, 4);
            case (len)
                2:       send_cp(CP_W'($urandom_range(0, 21'h7F)), 2, 1);
                3:       send_cp(CP_W'($urandom_range(0, 21'h7FF)), 3, 2);
                default: send_cp(CP_W'($urandom_range(0, 21'hFFFF)), 4, 3);
            endcase
        end
        else if (pick < 78)
            send_cp(CP_W'($urandom_range(21'h110000, 21'h1FFFFF)), 4, 3);
        else if (pick < 88)
        begin
            // cut the sequence short with a byte that is not a continuation
            len = $urandom_range(2, 4);
            send_cp(CP_W'($urandom_range(0, 21'h1FFFFF)), len, $urandom_range(0, len - 2));
            do
                b = 8'($urandom_range(0, 255));
            while (b[7:6] == 2'b10);
            send_byte(b);
        end
        else if (pick < 93)
        begin
            if ($urandom_range(0, 1))
                send_byte(8'($urandom_range(8'h80, 8'hBF)));
            else
                send_byte(8'($urandom_range(8'hF8, 8'hFF)));
        end
        else
        begin
            for (k = $urandom_range(1, 4); k > 0; k--)
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    // Hold push low so the last request is scored, and wait until no expected result is left.
    task automatic drain_results();
        push <= 1'b0;
        do
            @(posedge clk);
        while (sb.codepoint_q.size() != 0);
    endtask

    initial
    begin
        int phase;
        int phase_start;
        rst_n           = 1'b0;
        push            = 1'b0;
        pop             = 1'b0;
        byte_in         = 8'h00;
        sender_idle_pct = 0;
        stall_pct       = 0;
        bytes_sent      = 0;
        quiet_cycles    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // extremes, overlong, surrogate, max code point, above range, breaks at 2nd and 4th
        directed_seq = '{8'h00, 8'hFF, 8'h80,
                         8'hC0, 8'h80,
                         8'hE2, 8'h82, 8'hAC,
                         8'hED, 8'hA0, 8'h80,
                         8'hF4, 8'h8F, 8'hBF, 8'hBF,
                         8'hF4, 8'h90, 8'h80, 8'h80,
                         8'hE2, 8'h41,
                         8'hF0, 8'h9F, 8'h98, 8'hC2, 8'hA9};
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);
        drain_results();

        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin sender_idle_pct = 0;  stall_pct = 0;  end
                1:       begin sender_idle_pct = 66; stall_pct = 0;  end
                2:       begin sender_idle_pct = 0;  stall_pct = 66; end
                default: begin sender_idle_pct = 6;  stall_pct = 6;  end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
                send_random_unit();
            // hold the sender until every outstanding result is out
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.codepoint_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.codepoint_q.size()));
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
